/* hdl/ackermann_pose_odometry_top_macros.svh */
// Assertion macros shared by the odometry RTL.
`ifndef ACKERMANN_POSE_ODOMETRY_TOP_MACROS_SVH
`define ACKERMANN_POSE_ODOMETRY_TOP_MACROS_SVH

// Same-cycle implication, checked on clk and disabled while rst_n is low.
`define APO_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on clk and disabled while rst_n is low.
`define APO_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/apo_pkg.sv */
// Shared types, constants and the CORDIC arctangent table of the odometry block.
package apo_pkg;

  localparam int CORDIC_STEPS_DEF = 16;

  localparam logic [23:0] MPR_RESET = 24'd318767;
  localparam logic [23:0] IWB_RESET = 24'd252062;

  localparam logic signed [21:0] Q16_PI     = 22'sd205887;
  localparam logic signed [21:0] Q16_TWO_PI = 22'sd411775;
  localparam logic [18:0]        DTH_LIMIT  = 19'd411775;

  localparam logic signed [35:0] Q30_HALF_PI  = 36'sd1686629713;
  localparam logic signed [35:0] Q30_PI       = 36'sd3373259426;
  localparam logic signed [35:0] Q30_INV_GAIN = 36'sd652032874;

  localparam logic [23:0] TAN_LIMIT  = 24'hFFFFFF;
  localparam logic [32:0] DIST_LIMIT = 33'h100000000;

  // Distance division by 65536000 = 2^19 * 125. A rounded sum at or above
  // DIST_SAT_SUM gives a distance beyond the limit. The division by 125 uses
  // floor(2^38 / 125) on the sum shifted right by 22, then a short fix-up.
  localparam logic [67:0] DIST_SAT_SUM = 68'd281474976776192000;
  localparam logic [31:0] RECIP_125    = 32'd2199023255;
  localparam logic [8:0]  DIST_DIV_LO  = 9'd125;

  // Register indexes on the configuration port.
  localparam logic REG_MPR = 1'b0;
  localparam logic REG_IWB = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MUL_SE,
    ST_MUL_MPR,
    ST_DIV_D,
    ST_RECIP_D,
    ST_REM_D,
    ST_FIX_D,
    ST_COR_H,
    ST_WAIT_H,
    ST_MUL_C,
    ST_MUL_S,
    ST_ROUND_S,
    ST_COR_S,
    ST_WAIT_S,
    ST_WAIT_T,
    ST_MUL_W,
    ST_ROUND_W,
    ST_MUL_T,
    ST_ROUND_T,
    ST_TURN,
    ST_DONE
  } apo_state_t;

  // Arctangent of 2^-i in Q2.30.
  function automatic logic [31:0] atan_q30(input logic [4:0] idx);
    logic [31:0] v;
    unique case (idx)
      5'd0:  v = 32'h3243F6A8;
      5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;
      5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;
      5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;
      5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;
      5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;
      5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;
      5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;
      5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;
      5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;
      5'd23: v = 32'h0000007F;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

/* hdl/apo_if.sv */
// Valid/ready channel interfaces for input items and pose results.
interface apo_in_if;
  logic               valid;
  logic               ready;
  logic [15:0]        elapsed_ms;
  logic signed [18:0] wheel_speed;
  logic               speed_valid;
  logic signed [15:0] steer_angle;

  modport source (output valid, elapsed_ms, wheel_speed, speed_valid, steer_angle,
                  input ready);
  modport sink (input valid, elapsed_ms, wheel_speed, speed_valid, steer_angle,
                output ready);
endinterface

interface apo_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [18:0] heading;

  modport source (output valid, pos_x, pos_y, heading, input ready);
  modport sink (input valid, pos_x, pos_y, heading, output ready);
endinterface

/* hdl/apo_mul.sv */
// Shared unsigned multiplier with a registered product.
module apo_mul (
  input  logic        clk,
  input  logic [35:0] a,
  input  logic [31:0] b,
  output logic [67:0] prod
);
  logic [67:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= 68'(a) * 68'(b);
  end

  assign prod = prod_r;
endmodule

/* hdl/apo_div.sv */
// Restoring divider, one quotient bit per cycle.
module apo_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [51:0] dividend,
  input  logic [35:0] divisor,
  output logic [51:0] quotient,
  output logic        done
);
  logic [51:0] q_r, q_nxt;
  logic [35:0] rem_r, rem_nxt, dv_r, dv_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [36:0] trial;
  logic        fits;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dv_nxt   = dv_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, q_r[51]};
    fits     = trial >= {1'b0, dv_r};
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      dv_nxt   = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? 36'(trial - {1'b0, dv_r}) : trial[35:0];
      q_nxt   = {q_r[50:0], fits};
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd51) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dv_r  <= dv_nxt;
  end

  assign quotient = q_r;
  assign done     = done_r;
endmodule

/* hdl/apo_cordic.sv */
// Iterative rotation-mode CORDIC giving cosine and sine in Q2.30.
module apo_cordic #(
  parameter int STEPS = apo_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [35:0] z_in,
  output logic signed [35:0] cos_out,
  output logic signed [35:0] sin_out,
  output logic               done
);
  import apo_pkg::*;

  localparam int CW = $clog2(STEPS);

  logic signed [35:0] x_r, y_r, z_r, x_nxt, y_nxt, z_nxt;
  logic signed [35:0] dx, dy, at;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt, done_r, done_nxt;

  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    dx       = y_r >>> cnt_r;
    dy       = x_r >>> cnt_r;
    at       = 36'(atan_q30(5'(cnt_r)));
    if (start) begin
      y_nxt    = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
      // Angles beyond a quarter turn are first turned by pi.
      if (z_in > Q30_HALF_PI) begin
        x_nxt = -Q30_INV_GAIN;
        z_nxt = z_in - Q30_PI;
      end else if (z_in < -Q30_HALF_PI) begin
        x_nxt = -Q30_INV_GAIN;
        z_nxt = z_in + Q30_PI;
      end else begin
        x_nxt = Q30_INV_GAIN;
        z_nxt = z_in;
      end
    end else if (busy_r) begin
      if (z_r >= 0) begin
        x_nxt = x_r - dx;
        y_nxt = y_r + dy;
        z_nxt = z_r - at;
      end else begin
        x_nxt = x_r + dx;
        y_nxt = y_r - dy;
        z_nxt = z_r + at;
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

  assign cos_out = x_r;
  assign sin_out = y_r;
  assign done    = done_r;
endmodule

/* hdl/ackermann_pose_odometry_top.sv */
// Sequence: an item with a valid speed passes through the distance steps, two CORDIC runs
// and a divider pass for the tangent before its result is loaded; a saturated distance
// skips the reciprocal, remainder and fix-up steps, and a zero steering cosine skips the
// divider. An item with an invalid speed goes straight to the result state.
// Throughput: one item at a time; the next is taken the cycle after the result is loaded.
// Reset (synchronous, rst_n low): pose cleared to zero, registers to their defaults.
module ackermann_pose_odometry_top #(
  parameter int CORDIC_STEPS = apo_pkg::CORDIC_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  apo_in_if.sink      in_ch,
  apo_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import apo_pkg::*;

`include "ackermann_pose_odometry_top_macros.svh"

  // Configuration registers. Only the register index bit of the address is
  // decoded; writes are expected only while the block is idle.
  logic [23:0] mpr_r, iwb_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_IWB) ? {8'd0, iwb_r} : {8'd0, mpr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mpr_r <= MPR_RESET;
      iwb_r <= IWB_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_MPR: mpr_r <= pwdata[23:0];
        REG_IWB: iwb_r <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  // Shared arithmetic units: one multiplier, one divider and one CORDIC.
  logic [35:0]        mul_a;
  logic [31:0]        mul_b;
  logic [67:0]        prod;
  logic               div_start, div_done;
  logic [51:0]        div_dividend, quot;
  logic [35:0]        div_divisor;
  logic               cor_start, cor_done;
  logic signed [35:0] cor_z, cor_c, cor_s;

  apo_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod(prod));

  apo_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dividend),
    .divisor(div_divisor), .quotient(quot), .done(div_done)
  );

  apo_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst_n(rst_n), .start(cor_start), .z_in(cor_z),
    .cos_out(cor_c), .sin_out(cor_s), .done(cor_done)
  );

  // Sequencer state and item-wide values.
  apo_state_t         state_r, state_nxt;
  logic signed [31:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [20:0] h_r, h_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic signed [31:0] ox_r, ox_nxt, oy_r, oy_nxt;
  logic signed [18:0] oh_r, oh_nxt;

  logic [15:0]        el_r, el_nxt;
  logic signed [18:0] spd_r, spd_nxt;
  logic signed [15:0] st_r, st_nxt;
  logic [32:0]        dm_r, dm_nxt, w_r, w_nxt;
  logic [38:0]        qd_r, qd_nxt;
  logic [8:0]         rem_r, rem_nxt;
  logic [31:0]        hcm_r, hcm_nxt, hsm_r, hsm_nxt;
  logic               hcneg_r, hcneg_nxt, hsneg_r, hsneg_nxt, tneg_r, tneg_nxt;
  logic [35:0]        cm_r, cm_nxt, sm_r, sm_nxt;
  logic [23:0]        tm_r, tm_nxt;
  logic [18:0]        dth_r, dth_nxt;

  // Helper values of the datapath.
  logic [18:0]        spd_mag;
  logic               dneg;
  logic [67:0]        sum_d, sum_30, sum_16;
  logic [35:0]        cmag, smag;
  logic signed [35:0] rx, ry;
  logic signed [21:0] t0, t1, t2, dth_s;

  assign dneg    = spd_r[18];
  assign spd_mag = spd_r[18] ? 19'(-spd_r) : 19'(spd_r);
  assign sum_d   = prod + 68'd32768000;
  assign sum_30  = prod + 68'd536870912;
  assign sum_16  = prod + 68'd32768;
  assign cmag    = cor_c[35] ? 36'(-cor_c) : 36'(cor_c);
  assign smag    = cor_s[35] ? 36'(-cor_s) : 36'(cor_s);

  always_comb begin
    state_nxt     = state_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    h_nxt         = h_r;
    out_valid_nxt = out_valid_r;
    ox_nxt        = ox_r;
    oy_nxt        = oy_r;
    oh_nxt        = oh_r;
    el_nxt        = el_r;
    spd_nxt       = spd_r;
    st_nxt        = st_r;
    dm_nxt        = dm_r;
    w_nxt         = w_r;
    qd_nxt        = qd_r;
    rem_nxt       = rem_r;
    hcm_nxt       = hcm_r;
    hsm_nxt       = hsm_r;
    hcneg_nxt     = hcneg_r;
    hsneg_nxt     = hsneg_r;
    tneg_nxt      = tneg_r;
    cm_nxt        = cm_r;
    sm_nxt        = sm_r;
    tm_nxt        = tm_r;
    dth_nxt       = dth_r;
    mul_a         = '0;
    mul_b         = '0;
    div_start     = 1'b0;
    div_dividend  = '0;
    div_divisor   = '0;
    cor_start     = 1'b0;
    cor_z         = 36'(h_r) <<< 14;
    in_ch.ready   = 1'b0;
    rx            = '0;
    ry            = '0;
    dth_s         = $signed(22'(dth_r));
    t0            = '0;
    t1            = '0;
    t2            = '0;

    // A delivered result frees the output register.
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          el_nxt    = in_ch.elapsed_ms;
          spd_nxt   = in_ch.wheel_speed;
          st_nxt    = in_ch.steer_angle;
          state_nxt = in_ch.speed_valid ? ST_MUL_SE : ST_DONE;
        end
      end
      ST_MUL_SE: begin
        mul_a     = 36'(spd_mag);
        mul_b     = 32'(el_r);
        state_nxt = ST_MUL_MPR;
      end
      ST_MUL_MPR: begin
        mul_a     = prod[35:0];
        mul_b     = 32'(mpr_r);
        state_nxt = ST_DIV_D;
      end
      ST_DIV_D: begin
        // Rounded division by 65536000. A sum that would give more than the
        // distance limit saturates here; otherwise the shifted sum is divided
        // by 125 through a reciprocal estimate.
        if (sum_d >= DIST_SAT_SUM) begin
          dm_nxt    = DIST_LIMIT;
          state_nxt = ST_COR_H;
        end else begin
          qd_nxt    = sum_d[57:19];
          mul_a     = sum_d[57:22];
          mul_b     = RECIP_125;
          state_nxt = ST_RECIP_D;
        end
      end
      ST_RECIP_D: begin
        // The estimate is low by at most three; its product with 125 gives the remainder.
        dm_nxt    = prod[67:35];
        mul_a     = 36'(prod[67:35]);
        mul_b     = 32'(DIST_DIV_LO);
        state_nxt = ST_REM_D;
      end
      ST_REM_D: begin
        rem_nxt   = 9'(qd_r - prod[38:0]);
        state_nxt = ST_FIX_D;
      end
      ST_FIX_D: begin
        if (rem_r >= DIST_DIV_LO) begin
          rem_nxt = rem_r - DIST_DIV_LO;
          dm_nxt  = dm_r + 33'd1;
        end else begin
          state_nxt = ST_COR_H;
        end
      end
      ST_COR_H: begin
        cor_start = 1'b1;
        state_nxt = ST_WAIT_H;
      end
      ST_WAIT_H: begin
        if (cor_done) begin
          hcm_nxt   = cmag[31:0];
          hsm_nxt   = smag[31:0];
          hcneg_nxt = cor_c[35];
          hsneg_nxt = cor_s[35];
          state_nxt = ST_MUL_C;
        end
      end
      ST_MUL_C: begin
        mul_a     = 36'(dm_r);
        mul_b     = hcm_r;
        state_nxt = ST_MUL_S;
      end
      ST_MUL_S: begin
        cm_nxt    = sum_30[65:30];
        mul_a     = 36'(dm_r);
        mul_b     = hsm_r;
        state_nxt = ST_ROUND_S;
      end
      ST_ROUND_S: begin
        sm_nxt    = sum_30[65:30];
        state_nxt = ST_COR_S;
      end
      ST_COR_S: begin
        cor_start = 1'b1;
        cor_z     = 36'(st_r) <<< 16;
        state_nxt = ST_WAIT_S;
      end
      ST_WAIT_S: begin
        if (cor_done) begin
          tneg_nxt = cor_s[35] != cor_c[35];
          if (cor_c == 0) begin
            // A zero cosine gives the saturated tangent.
            tm_nxt    = TAN_LIMIT;
            state_nxt = ST_MUL_W;
          end else begin
            div_start    = 1'b1;
            div_dividend = 52'(smag) << 16;
            div_divisor  = cmag;
            state_nxt    = ST_WAIT_T;
          end
        end
      end
      ST_WAIT_T: begin
        if (div_done) begin
          tm_nxt    = (quot > 52'(TAN_LIMIT)) ? TAN_LIMIT : quot[23:0];
          state_nxt = ST_MUL_W;
        end
      end
      ST_MUL_W: begin
        mul_a     = 36'(dm_r);
        mul_b     = 32'(iwb_r);
        state_nxt = ST_ROUND_W;
      end
      ST_ROUND_W: begin
        w_nxt     = (sum_16[67:16] > 52'(DIST_LIMIT)) ? DIST_LIMIT : sum_16[48:16];
        state_nxt = ST_MUL_T;
      end
      ST_MUL_T: begin
        mul_a     = 36'(w_r);
        mul_b     = 32'(tm_r);
        state_nxt = ST_ROUND_T;
      end
      ST_ROUND_T: begin
        // Heading increment clamps at two pi; x and y move along the old heading.
        dth_nxt = (sum_16[67:16] > 52'(DTH_LIMIT)) ? DTH_LIMIT : sum_16[34:16];
        rx = 36'(x_r) + ((dneg != hcneg_r) ? -$signed(cm_r) : $signed(cm_r));
        ry = 36'(y_r) + ((dneg != hsneg_r) ? -$signed(sm_r) : $signed(sm_r));
        if (rx > 36'sd2147483647) begin
          x_nxt = 32'sh7FFFFFFF;
        end else if (rx < -36'sd2147483648) begin
          x_nxt = 32'sh80000000;
        end else begin
          x_nxt = rx[31:0];
        end
        if (ry > 36'sd2147483647) begin
          y_nxt = 32'sh7FFFFFFF;
        end else if (ry < -36'sd2147483648) begin
          y_nxt = 32'sh80000000;
        end else begin
          y_nxt = ry[31:0];
        end
        state_nxt = ST_TURN;
      end
      ST_TURN: begin
        // One wrap brings the heading back into minus pi to pi.
        t0 = 22'(h_r) + ((dneg != tneg_r) ? -dth_s : dth_s);
        t1 = (t0 < -Q16_PI) ? t0 + Q16_TWO_PI : t0;
        t2 = (t1 > Q16_PI) ? t1 - Q16_TWO_PI : t1;
        h_nxt     = t2[20:0];
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          ox_nxt        = x_r;
          oy_nxt        = y_r;
          oh_nxt        = h_r[18:0];
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      x_r         <= '0;
      y_r         <= '0;
      h_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      x_r         <= x_nxt;
      y_r         <= y_nxt;
      h_r         <= h_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ox_r    <= ox_nxt;
    oy_r    <= oy_nxt;
    oh_r    <= oh_nxt;
    el_r    <= el_nxt;
    spd_r   <= spd_nxt;
    st_r    <= st_nxt;
    dm_r    <= dm_nxt;
    w_r     <= w_nxt;
    qd_r    <= qd_nxt;
    rem_r   <= rem_nxt;
    hcm_r   <= hcm_nxt;
    hsm_r   <= hsm_nxt;
    hcneg_r <= hcneg_nxt;
    hsneg_r <= hsneg_nxt;
    tneg_r  <= tneg_nxt;
    cm_r    <= cm_nxt;
    sm_r    <= sm_nxt;
    tm_r    <= tm_nxt;
    dth_r   <= dth_nxt;
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.pos_x   = ox_r;
  assign out_ch.pos_y   = oy_r;
  assign out_ch.heading = oh_r;

  `APO_ASSERT_NXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready, "input taken while busy")
  `APO_ASSERT_IMP(a_heading_wrapped, 1'b1, (22'(h_r) >= -Q16_PI) && (22'(h_r) <= Q16_PI), "heading outside minus pi to pi")
  `APO_ASSERT_IMP(a_div_done_expected, div_done, state_r == ST_WAIT_T, "divider finished unexpectedly")
  `APO_ASSERT_IMP(a_cordic_done_expected, cor_done, (state_r == ST_WAIT_H) || (state_r == ST_WAIT_S), "CORDIC finished unexpectedly")
endmodule
